### hdl/htts_pkg.sv
// ----------------------------------------------------------------------------
// htts_pkg
// Shared types, constants and the byte classifier for the html text stripper
// ----------------------------------------------------------------------------
package htts_pkg;

  localparam int MAX_ENTITY_NAME = 9;
  localparam int SPACE_BITS      = 16;
  localparam int QDEPTH          = 4;

  localparam int QPTR_BITS       = $clog2(QDEPTH);
  localparam int QCNT_BITS       = $clog2(QDEPTH + 1);
  localparam int EBUF_IDX_BITS   = $clog2(MAX_ENTITY_NAME);
  localparam int ELEN_BITS       = $clog2(MAX_ENTITY_NAME + 1);
  localparam int RP_DEPTH        = MAX_ENTITY_NAME + 1;
  localparam int RP_IDX_BITS     = $clog2(RP_DEPTH);
  localparam int RPLEN_BITS      = $clog2(RP_DEPTH + 1);
  localparam int MATCH_BITS      = 4;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_TAG,
    MODE_OPEN,
    MODE_OPEN_SCRIPT,
    MODE_OPEN_STYLE,
    MODE_SKIP_SCRIPT,
    MODE_SKIP_STYLE,
    MODE_ENTITY
  } mode_t;

  typedef enum logic [1:0] {
    ACT_IDLE,
    ACT_BYTE,
    ACT_END_FAIL,
    ACT_END
  } act_t;

  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] low;
    logic       is_lt;
    logic       is_gt;
    logic       is_amp;
    logic       is_semi;
    logic       is_ws;
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic last;
  } q_item_t;

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    c.raw     = b;
    c.low     = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    c.is_lt   = (b == CH_LT);
    c.is_gt   = (b == CH_GT);
    c.is_amp  = (b == CH_AMP);
    c.is_semi = (b == CH_SEMI);
    c.is_ws   = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    return c;
  endfunction

endpackage

### hdl/htts_front.sv
// ----------------------------------------------------------------------------
// htts_front
// Input side: classifies each byte and holds it in a short queue for the parser
// ----------------------------------------------------------------------------
module htts_front import htts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       q_valid,
  output q_item_t    q_item,
  input  logic       q_pop
);

  q_item_t              mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 push;
  logic                 pop;
  q_item_t              item_in;

  assign in_stall = (count == QCNT_BITS'(QDEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  always_comb begin
    item_in.cls  = classify(in_byte);
    item_in.last = in_last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/htts_back.sv
// ----------------------------------------------------------------------------
// htts_back
// Parser: tag, script/style, entity and whitespace handling, one byte a cycle
// while no held result beat stalls it, with entity replay and a registered result stage
// ----------------------------------------------------------------------------
module htts_back import htts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  q_item_t               q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char,
  output logic                  char_valid,
  output logic [SPACE_BITS-1:0] space_run,
  output logic                  out_end
);

  localparam logic [SPACE_BITS-1:0] SPACE_MAX  = {SPACE_BITS{1'b1}};
  localparam logic [MATCH_BITS-1:0] SCRIPT_END = MATCH_BITS'(5);
  localparam logic [MATCH_BITS-1:0] STYLE_END  = MATCH_BITS'(4);
  localparam logic [MATCH_BITS-1:0] CSCR_END   = MATCH_BITS'(7);
  localparam logic [MATCH_BITS-1:0] CSTY_END   = MATCH_BITS'(6);

  function automatic logic [7:0] script_chr(input logic [MATCH_BITS-1:0] i);
    case (i)
      MATCH_BITS'(0): return "s";
      MATCH_BITS'(1): return "c";
      MATCH_BITS'(2): return "r";
      MATCH_BITS'(3): return "i";
      MATCH_BITS'(4): return "p";
      MATCH_BITS'(5): return "t";
      default:        return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] style_chr(input logic [MATCH_BITS-1:0] i);
    case (i)
      MATCH_BITS'(0): return "s";
      MATCH_BITS'(1): return "t";
      MATCH_BITS'(2): return "y";
      MATCH_BITS'(3): return "l";
      MATCH_BITS'(4): return "e";
      default:        return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] close_script_chr(input logic [MATCH_BITS-1:0] i);
    case (i)
      MATCH_BITS'(0): return "<";
      MATCH_BITS'(1): return "/";
      default:        return script_chr(i - MATCH_BITS'(2));
    endcase
  endfunction

  function automatic logic [7:0] close_style_chr(input logic [MATCH_BITS-1:0] i);
    case (i)
      MATCH_BITS'(0): return "<";
      MATCH_BITS'(1): return "/";
      default:        return style_chr(i - MATCH_BITS'(2));
    endcase
  endfunction

  mode_t                  mode;
  mode_t                  mode_next;
  logic [MATCH_BITS-1:0]  mp;
  logic [MATCH_BITS-1:0]  mp_next;
  logic [ELEN_BITS-1:0]   elen;
  logic [ELEN_BITS-1:0]   elen_next;
  logic [7:0]             ebuf [MAX_ENTITY_NAME];
  logic [SPACE_BITS-1:0]  held;
  logic [SPACE_BITS-1:0]  held_next;
  logic                   started;
  logic                   started_next;
  logic                   end_pend;
  logic                   end_pend_next;
  logic [7:0]             rp [RP_DEPTH];
  logic [RPLEN_BITS-1:0]  rp_len;
  logic [RPLEN_BITS-1:0]  rp_len_next;
  logic [RPLEN_BITS-1:0]  rp_pos;
  logic [RPLEN_BITS-1:0]  rp_pos_next;
  logic                   buf_we;
  logic                   rp_load;

  logic                   rp_act;
  act_t                   act;
  cls_t                   cur;
  logic                   cur_last;
  logic                   out_free;
  logic                   step;
  logic                   res_emit;
  logic                   res_end;
  logic [7:0]             res_char;
  logic                   ent_hit;
  logic [7:0]             ent_char;

  // source select: replay first, then end handling, then the queue
  assign rp_act   = (rp_pos < rp_len);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    act      = ACT_IDLE;
    cur      = classify(rp[rp_pos[RP_IDX_BITS-1:0]]);
    cur_last = 1'b0;
    if (rp_act) begin
      act = ACT_BYTE;
    end else if (end_pend) begin
      act = (mode == MODE_ENTITY) ? ACT_END_FAIL : ACT_END;
    end else if (q_valid) begin
      act      = ACT_BYTE;
      cur      = q_item.cls;
      cur_last = q_item.last;
    end
  end

  // entity name lookup
  always_comb begin
    ent_hit  = 1'b1;
    ent_char = CH_AMP;
    if (elen == ELEN_BITS'(3) && ebuf[0] == "a" && ebuf[1] == "m" && ebuf[2] == "p") begin
      ent_char = CH_AMP;
    end else if (elen == ELEN_BITS'(2) && ebuf[0] == "l" && ebuf[1] == "t") begin
      ent_char = CH_LT;
    end else if (elen == ELEN_BITS'(2) && ebuf[0] == "g" && ebuf[1] == "t") begin
      ent_char = CH_GT;
    end else if (elen == ELEN_BITS'(4) && ebuf[0] == "q" && ebuf[1] == "u" &&
                 ebuf[2] == "o" && ebuf[3] == "t") begin
      ent_char = CH_QUOT;
    end else if (elen == ELEN_BITS'(4) && ebuf[0] == "a" && ebuf[1] == "p" &&
                 ebuf[2] == "o" && ebuf[3] == "s") begin
      ent_char = CH_APOS;
    end else begin
      ent_hit = 1'b0;
    end
  end

  // result of this step
  always_comb begin
    res_emit = 1'b0;
    res_end  = 1'b0;
    res_char = cur.raw;
    case (act)
      ACT_BYTE: begin
        case (mode)
          MODE_TEXT: begin
            res_emit = !cur.is_lt && !cur.is_amp && !cur.is_ws;
          end
          MODE_ENTITY: begin
            if (cur.is_semi) begin
              res_emit = ent_hit;
              res_char = ent_char;
            end else if (elen == ELEN_BITS'(MAX_ENTITY_NAME)) begin
              res_emit = 1'b1;
              res_char = CH_AMP;
            end
          end
          default: res_emit = 1'b0;
        endcase
      end
      ACT_END_FAIL: begin
        res_emit = 1'b1;
        res_char = CH_AMP;
      end
      ACT_END: begin
        res_emit = 1'b1;
        res_end  = 1'b1;
      end
      default: res_emit = 1'b0;
    endcase
  end

  assign step  = (act != ACT_IDLE) && (!res_emit || out_free);
  assign q_pop = step && (act == ACT_BYTE) && !rp_act;

  // next state
  always_comb begin
    mode_next     = mode;
    mp_next       = mp;
    elen_next     = elen;
    held_next     = held;
    started_next  = started;
    end_pend_next = end_pend;
    rp_len_next   = rp_len;
    rp_pos_next   = rp_pos;
    buf_we        = 1'b0;
    rp_load       = 1'b0;
    case (act)
      ACT_BYTE: begin
        if (rp_act) begin
          rp_pos_next = rp_pos + RPLEN_BITS'(1);
        end else if (cur_last) begin
          end_pend_next = 1'b1;
        end
        case (mode)
          MODE_TEXT: begin
            if (cur.is_lt) begin
              if (started && held == '0) held_next = SPACE_BITS'(1);
              mode_next = MODE_OPEN;
              mp_next   = '0;
            end else if (cur.is_amp) begin
              mode_next = MODE_ENTITY;
              elen_next = '0;
            end else if (cur.is_ws) begin
              if (started && held == '0) held_next = SPACE_BITS'(1);
            end
          end
          MODE_TAG: begin
            if (cur.is_gt) mode_next = MODE_TEXT;
          end
          MODE_OPEN: begin
            if (mp == '0 && cur.low == "s") begin
              mp_next = MATCH_BITS'(1);
            end else if (mp == MATCH_BITS'(1) && cur.low == "c") begin
              mode_next = MODE_OPEN_SCRIPT;
              mp_next   = MATCH_BITS'(2);
            end else if (mp == MATCH_BITS'(1) && cur.low == "t") begin
              mode_next = MODE_OPEN_STYLE;
              mp_next   = MATCH_BITS'(2);
            end else begin
              mode_next = cur.is_gt ? MODE_TEXT : MODE_TAG;
              mp_next   = '0;
            end
          end
          MODE_OPEN_SCRIPT: begin
            if (cur.low == script_chr(mp)) begin
              if (mp == SCRIPT_END) begin
                if (started && held == '0) held_next = SPACE_BITS'(1);
                mode_next = MODE_SKIP_SCRIPT;
                mp_next   = '0;
              end else begin
                mp_next = mp + MATCH_BITS'(1);
              end
            end else begin
              mode_next = cur.is_gt ? MODE_TEXT : MODE_TAG;
              mp_next   = '0;
            end
          end
          MODE_OPEN_STYLE: begin
            if (cur.low == style_chr(mp)) begin
              if (mp == STYLE_END) begin
                if (started && held == '0) held_next = SPACE_BITS'(1);
                mode_next = MODE_SKIP_STYLE;
                mp_next   = '0;
              end else begin
                mp_next = mp + MATCH_BITS'(1);
              end
            end else begin
              mode_next = cur.is_gt ? MODE_TEXT : MODE_TAG;
              mp_next   = '0;
            end
          end
          MODE_SKIP_SCRIPT: begin
            if (cur.low == close_script_chr(mp)) begin
              if (mp == CSCR_END) begin
                mode_next = MODE_TAG;
                mp_next   = '0;
              end else begin
                mp_next = mp + MATCH_BITS'(1);
              end
            end else begin
              mp_next = cur.is_lt ? MATCH_BITS'(1) : '0;
            end
          end
          MODE_SKIP_STYLE: begin
            if (cur.low == close_style_chr(mp)) begin
              if (mp == CSTY_END) begin
                mode_next = MODE_TAG;
                mp_next   = '0;
              end else begin
                mp_next = mp + MATCH_BITS'(1);
              end
            end else begin
              mp_next = cur.is_lt ? MATCH_BITS'(1) : '0;
            end
          end
          default: begin
            if (cur.is_semi) begin
              if (!ent_hit && held != SPACE_MAX) held_next = held + SPACE_BITS'(1);
              mode_next = MODE_TEXT;
              elen_next = '0;
            end else if (elen < ELEN_BITS'(MAX_ENTITY_NAME)) begin
              buf_we    = 1'b1;
              elen_next = elen + ELEN_BITS'(1);
            end else begin
              mode_next   = MODE_TEXT;
              elen_next   = '0;
              rp_load     = 1'b1;
              rp_len_next = RPLEN_BITS'(RP_DEPTH);
              rp_pos_next = '0;
            end
          end
        endcase
      end
      ACT_END_FAIL: begin
        mode_next   = MODE_TEXT;
        elen_next   = '0;
        rp_load     = 1'b1;
        rp_len_next = RPLEN_BITS'(elen);
        rp_pos_next = '0;
      end
      ACT_END: begin
        mode_next     = MODE_TEXT;
        mp_next       = '0;
        elen_next     = '0;
        held_next     = '0;
        started_next  = 1'b0;
        end_pend_next = 1'b0;
        rp_len_next   = '0;
        rp_pos_next   = '0;
      end
      default: mode_next = mode;
    endcase
    if (res_emit && !res_end) begin
      held_next    = '0;
      started_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_TEXT;
      mp       <= '0;
      elen     <= '0;
      held     <= '0;
      started  <= 1'b0;
      end_pend <= 1'b0;
      rp_len   <= '0;
      rp_pos   <= '0;
    end else if (step) begin
      mode     <= mode_next;
      mp       <= mp_next;
      elen     <= elen_next;
      held     <= held_next;
      started  <= started_next;
      end_pend <= end_pend_next;
      rp_len   <= rp_len_next;
      rp_pos   <= rp_pos_next;
    end
  end

  // entity name buffer and replay copy
  always_ff @(posedge clk) begin
    if (step && buf_we) begin
      ebuf[elen[EBUF_IDX_BITS-1:0]] <= cur.raw;
    end
    if (step && rp_load) begin
      for (int k = 0; k < MAX_ENTITY_NAME; k++) begin
        rp[k] <= ebuf[k];
      end
      rp[MAX_ENTITY_NAME] <= cur.raw;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_emit) begin
      out_char   <= res_end ? 8'h00 : res_char;
      char_valid <= !res_end;
      space_run  <= res_end ? '0 : held;
      out_end    <= res_end;
    end
  end

`ifndef SYNTHESIS
  a_rp_bound: assert property (@(posedge clk) disable iff (rst)
    rp_pos <= rp_len)
    else $error("replay position past replay length");

  a_elen_bound: assert property (@(posedge clk) disable iff (rst)
    elen <= ELEN_BITS'(MAX_ENTITY_NAME))
    else $error("entity length out of range");

  a_no_pop_in_replay: assert property (@(posedge clk) disable iff (rst)
    rp_act |-> !q_pop)
    else $error("queue popped during replay");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (step && act == ACT_END) |=> (mode == MODE_TEXT && held == '0 && !started && !end_pend))
    else $error("state not cleared after end beat");

  a_end_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_end) |-> (!char_valid && space_run == '0))
    else $error("end beat carries a character");
`endif

endmodule

### hdl/html_to_text_stripper_top.sv
// ----------------------------------------------------------------------------
// html_to_text_stripper_top
// HTML byte stream in, readable text characters with space counts out.
//
// Input channel: one document byte per beat (in_byte, in_last marks the final
// byte), accepted when in_valid is high and in_stall is low.
// Output channel: one beat per character (out_char, char_valid, space_run),
// plus a bare end beat with out_end set after the last byte of a document.
// A byte accepted into the queue passes through the result register before its
// beat appears. Throughput: one byte per cycle while the receiver does not stall,
// set by the parser stepping one byte a cycle from a four-entry queue, plus a
// parser step for the end beat of each document. An entity name that overruns
// nine bytes replays ten bytes, the parser taking no byte from the queue while
// it replays them; intake stalls once the queue fills. An entity still open at
// document end gives an '&' beat and replays its name bytes before the end beat.
// Reset (rst, synchronous) empties the queue and returns the parser to text
// mode with no held spaces. When the receiver stalls, the result register
// holds its beat, the parser stops at the next byte that would give a beat,
// and the queue fills until in_stall rises.
// ----------------------------------------------------------------------------
module html_to_text_stripper_top import htts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char,
  output logic                  char_valid,
  output logic [SPACE_BITS-1:0] space_run,
  output logic                  out_end
);

  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  htts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  htts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .char_valid (char_valid),
    .space_run  (space_run),
    .out_end    (out_end)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for html_to_text_stripper_top. Feeds whole HTML documents one
// byte per beat, with random gaps on the input side and random stalls on the
// output side. Every accepted byte is run through a behavioural copy of the
// stripper, and each output beat is checked field by field against the
// oldest predicted beat. Covers tags, skipped script and style elements,
// entities, entity overrun and replay, open entities at document end and
// unterminated tags.
// ----------------------------------------------------------------------------
module tb_top;
  import htts_pkg::*;

  localparam int GAP_MAX    = (1 << SPACE_BITS) - 1;
  localparam int BEAT_CAP   = MAX_ENTITY_NAME + 3;
  localparam int REPLAY_MAX = 2 * MAX_ENTITY_NAME + 4;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } doc_byte_t;

  typedef struct packed {
    logic [7:0]            ch;
    logic                  is_char;
    logic [SPACE_BITS-1:0] gap;
    logic                  is_end;
  } text_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte = 8'h00;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_char;
  logic                  char_valid;
  logic [SPACE_BITS-1:0] space_run;
  logic                  out_end;

  html_to_text_stripper_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .char_valid (char_valid),
    .space_run  (space_run),
    .out_end    (out_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  doc_byte_t  feed_q[$];
  logic [7:0] doc[$];
  text_beat_t expected_text[$];

  int fails      = 0;
  int bytes_sent = 0;
  int chars_seen = 0;
  int ends_seen  = 0;
  int widest_gap = 0;
  int cyc        = 0;

  // ---------------------------------------------------------------------------
  // stripper state
  // ---------------------------------------------------------------------------
  mode_t      sm_mode = MODE_TEXT;
  int         sm_match = 0;
  logic [7:0] ent_name[MAX_ENTITY_NAME];
  int         ent_len = 0;
  int         held_gap = 0;
  bit         text_started = 0;
  logic [7:0] replay_buf[REPLAY_MAX];
  int         replay_len = 0;
  int         replay_pos = 0;
  int         beats_now = 0;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic void clear_model();
    sm_mode = MODE_TEXT;
    sm_match = 0;
    ent_len = 0;
    held_gap = 0;
    text_started = 0;
    foreach (ent_name[i]) ent_name[i] = 8'h00;
  endfunction

  function automatic void put_beat(input logic [7:0] c, input logic v, input int run,
                                   input logic e);
    text_beat_t t;
    if (beats_now < BEAT_CAP) begin
      t.ch = c;
      t.is_char = v;
      t.gap = SPACE_BITS'((run > GAP_MAX) ? GAP_MAX : run);
      t.is_end = e;
      expected_text.insert(expected_text.size(), t);
      beats_now++;
    end
  endfunction

  function automatic void emit_text(input logic [7:0] c);
    put_beat(c, 1'b1, held_gap, 1'b0);
    held_gap = 0;
    text_started = 1;
  endfunction

  function automatic void add_gap();
    if (held_gap < GAP_MAX) held_gap++;
  endfunction

  function automatic void word_break();
    if (text_started && held_gap == 0) held_gap = 1;
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    if (replay_len < REPLAY_MAX) begin
      replay_buf[replay_len] = b;
      replay_len++;
    end
  endfunction

  function automatic bit name_is(input string s);
    if (ent_len != s.len()) return 0;
    for (int i = 0; i < ent_len; i++)
      if (ent_name[i] != s[i]) return 0;
    return 1;
  endfunction

  function automatic void decode_name();
    if (name_is("amp")) emit_text(CH_AMP);
    else if (name_is("lt")) emit_text(CH_LT);
    else if (name_is("gt")) emit_text(CH_GT);
    else if (name_is("quot")) emit_text(CH_QUOT);
    else if (name_is("apos")) emit_text(CH_APOS);
    else add_gap();
  endfunction

  function automatic void abandon_entity();
    emit_text(CH_AMP);
    sm_mode = MODE_TEXT;
    for (int k = 0; k < ent_len && k < MAX_ENTITY_NAME; k++) queue_byte(ent_name[k]);
    ent_len = 0;
  endfunction

  function automatic void tag_miss(input logic [7:0] b);
    sm_mode = (b == CH_GT) ? MODE_TEXT : MODE_TAG;
    sm_match = 0;
  endfunction

  function automatic void open_step(input logic [7:0] b, input string pat, input mode_t nxt);
    if (sm_match < pat.len() && fold_case(b) == pat[sm_match]) begin
      sm_match++;
      if (sm_match == pat.len()) begin
        word_break();
        sm_mode = nxt;
        sm_match = 0;
      end
    end else begin
      tag_miss(b);
    end
  endfunction

  function automatic void skip_step(input logic [7:0] b, input string pat);
    if (sm_match < pat.len() && fold_case(b) == pat[sm_match]) sm_match++;
    else sm_match = (b == CH_LT) ? 1 : 0;
    if (sm_match >= pat.len()) begin
      sm_mode = MODE_TAG;
      sm_match = 0;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [7:0] lb;
    lb = fold_case(b);
    case (sm_mode)
      MODE_TEXT: begin
        if (b == CH_LT) begin
          word_break();
          sm_mode = MODE_OPEN;
          sm_match = 0;
        end else if (b == CH_AMP) begin
          sm_mode = MODE_ENTITY;
          ent_len = 0;
        end else if (is_blank(b)) begin
          word_break();
        end else begin
          emit_text(b);
        end
      end
      MODE_TAG: begin
        if (b == CH_GT) sm_mode = MODE_TEXT;
      end
      MODE_OPEN: begin
        if (sm_match == 0 && lb == "s") begin
          sm_match = 1;
        end else if (sm_match == 1 && lb == "c") begin
          sm_mode = MODE_OPEN_SCRIPT;
          sm_match = 2;
        end else if (sm_match == 1 && lb == "t") begin
          sm_mode = MODE_OPEN_STYLE;
          sm_match = 2;
        end else begin
          tag_miss(b);
        end
      end
      MODE_OPEN_SCRIPT: open_step(b, "script", MODE_SKIP_SCRIPT);
      MODE_OPEN_STYLE:  open_step(b, "style", MODE_SKIP_STYLE);
      MODE_SKIP_SCRIPT: skip_step(b, "</script");
      MODE_SKIP_STYLE:  skip_step(b, "</style");
      default: begin
        if (b == CH_SEMI) begin
          decode_name();
          sm_mode = MODE_TEXT;
          ent_len = 0;
        end else if (ent_len < MAX_ENTITY_NAME) begin
          ent_name[ent_len] = b;
          ent_len++;
        end else begin
          abandon_entity();
          queue_byte(b);
        end
      end
    endcase
  endfunction

  function automatic void run_replay();
    while (replay_pos < replay_len) begin
      replay_pos++;
      parse_byte(replay_buf[replay_pos - 1]);
    end
    replay_pos = 0;
    replay_len = 0;
  endfunction

  function automatic void strip_byte(input logic [7:0] b, input logic last);
    beats_now = 0;
    replay_len = 0;
    replay_pos = 0;
    queue_byte(b);
    run_replay();
    if (last) begin
      for (int g = 0; sm_mode == MODE_ENTITY && g <= MAX_ENTITY_NAME + 1; g++) begin
        abandon_entity();
        run_replay();
      end
      put_beat(8'h00, 1'b0, 0, 1'b1);
      clear_model();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // document building
  // ---------------------------------------------------------------------------
  function automatic void doc_put(input logic [7:0] b);
    doc.insert(doc.size(), b);
  endfunction

  function automatic logic [7:0] any_case(input logic [7:0] b);
    if (b >= "a" && b <= "z" && $urandom_range(0, 1) == 1) return b - 8'd32;
    return b;
  endfunction

  function automatic logic [7:0] letter();
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  task automatic add_text(input string s, input bit mixed);
    for (int i = 0; i < s.len(); i++) doc_put(mixed ? any_case(s[i]) : s[i]);
  endtask

  task automatic add_letters(input int n);
    repeat (n) doc_put(letter());
  endtask

  function automatic string entity_word(input int k);
    case (k)
      0: return "amp";
      1: return "lt";
      2: return "gt";
      3: return "quot";
      4: return "apos";
      default: return "nbsp";
    endcase
  endfunction

  function automatic string near_miss(input int k);
    case (k)
      0: return "<s";
      1: return "<sc";
      2: return "<scr";
      3: return "<scrip";
      4: return "<st";
      5: return "<sty";
      default: return "<styl";
    endcase
  endfunction

  task automatic flush_doc();
    doc_byte_t e;
    foreach (doc[i]) begin
      e.data = doc[i];
      e.last = (i == doc.size() - 1);
      feed_q.insert(feed_q.size(), e);
    end
    doc.delete();
  endtask

  task automatic add_piece(input int kind);
    logic [7:0] b;
    string name;
    int n;
    case (kind)
      0, 1, 2, 3: begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          b = 8'($urandom_range(33, 126));
          if (b == CH_LT || b == CH_AMP) b = "k";
          doc_put(b);
        end
      end
      4: begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: doc_put(CH_SPACE);
            1: doc_put(CH_TAB);
            2: doc_put(CH_LF);
            default: doc_put(CH_CR);
          endcase
        end
      end
      5: begin
        doc_put(CH_LT);
        if ($urandom_range(0, 3) == 0) doc_put("/");
        add_letters($urandom_range(1, 5));
        if ($urandom_range(0, 1) == 1) add_text(" x=1", 0);
        doc_put(CH_GT);
      end
      6, 7: begin
        if (kind == 6) name = "script";
        else name = "style";
        doc_put(CH_LT);
        add_text(name, 1);
        if ($urandom_range(0, 1) == 1) add_text(" t=\"a\"", 0);
        doc_put(CH_GT);
        n = $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: doc_put(CH_LT);
            1: doc_put("/");
            2: doc_put(CH_GT);
            3: doc_put(CH_AMP);
            default: doc_put(letter());
          endcase
        end
        if ($urandom_range(0, 2) == 0) add_text("</s", 1);
        add_text("</", 0);
        add_text(name, 1);
        if ($urandom_range(0, 1) == 1) doc_put(CH_SPACE);
        doc_put(CH_GT);
      end
      8: begin
        doc_put(CH_AMP);
        add_text(entity_word($urandom_range(0, 5)), 0);
        doc_put(CH_SEMI);
      end
      9: begin
        doc_put(CH_AMP);
        if ($urandom_range(0, 1) == 1) begin
          doc_put("#");
          n = $urandom_range(1, 5);
          repeat (n) doc_put(8'("0" + $urandom_range(0, 9)));
        end else begin
          add_letters($urandom_range(0, MAX_ENTITY_NAME));
        end
        doc_put(CH_SEMI);
      end
      10: begin
        doc_put(CH_AMP);
        add_letters($urandom_range(MAX_ENTITY_NAME + 1, MAX_ENTITY_NAME + 3));
        if ($urandom_range(0, 1) == 1) doc_put(CH_SEMI);
      end
      11: begin
        add_text(near_miss($urandom_range(0, 6)), 1);
        if ($urandom_range(0, 1) == 1) doc_put(8'("0" + $urandom_range(0, 9)));
        doc_put(CH_GT);
      end
      12: begin
        n = $urandom_range(1, 3);
        repeat (n) doc_put(8'($urandom_range(0, 255)));
      end
      13: begin
        n = $urandom_range(1, 3);
        repeat (n) doc_put(8'($urandom_range(128, 255)));
      end
      14: begin
        doc_put(CH_AMP);
        add_letters(MAX_ENTITY_NAME - 2);
        doc_put(CH_AMP);
        add_text(entity_word($urandom_range(0, 2)), 0);
        doc_put(CH_SEMI);
      end
      default: begin
        case ($urandom_range(0, 2))
          0: doc_put(CH_GT);
          1: doc_put(CH_SEMI);
          default: add_text("</x>", 0);
        endcase
      end
    endcase
  endtask

  task automatic make_doc();
    int n;
    n = $urandom_range(2, 7);
    repeat (n) add_piece($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0: begin
        doc_put(CH_LT);
        add_letters($urandom_range(0, 3));
      end
      1: begin
        doc_put(CH_AMP);
        add_letters($urandom_range(0, 5));
      end
      default: ;
    endcase
    flush_doc();
  endtask

  // ---------------------------------------------------------------------------
  // driver and monitor
  // ---------------------------------------------------------------------------
  function automatic bit busy_window();
    return (cyc % 4096) >= 700;
  endfunction

  always @(posedge clk) cyc <= cyc + 1;

  doc_byte_t  nxt;
  text_beat_t want;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        strip_byte(in_byte, in_last);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (feed_q.size() != 0 && !(busy_window() && $urandom_range(0, 99) < 30)) begin
          nxt = feed_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= nxt.data;
          in_last <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= busy_window() && $urandom_range(0, 99) < 30;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        $error("unexpected beat: out_char %h char_valid %b space_run %0d out_end %b",
               out_char, char_valid, space_run, out_end);
        fails++;
      end else begin
        want = expected_text.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, out_char);
          fails++;
        end
        if (char_valid !== want.is_char) begin
          $error("char_valid: expected %b, got %b", want.is_char, char_valid);
          fails++;
        end
        if (space_run !== want.gap) begin
          $error("space_run: expected %0d, got %0d", want.gap, space_run);
          fails++;
        end
        if (out_end !== want.is_end) begin
          $error("out_end: expected %b, got %b", want.is_end, out_end);
          fails++;
        end
        if (want.is_end) ends_seen++;
        else chars_seen++;
        if (want.gap > widest_gap) widest_gap = want.gap;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int base;
    clear_model();

    // entity space at the start, blank, near-miss prefix closed by '>'
    add_text("&;X <Sc>y", 0);
    flush_doc();
    // style element skipped, closing tag with trailing attribute space
    add_text("a<STYLE>z</sTyle >b", 0);
    flush_doc();
    // byte extremes, entity overrun with replay, entity open at the end
    doc_put(8'h00);
    doc_put(8'hFF);
    add_text("&abcdefghij;&q", 0);
    flush_doc();
    // unterminated tag swallows the rest
    add_text("x<pq", 0);
    flush_doc();
    // unterminated script element
    add_text("<script>a&amp;", 0);
    flush_doc();
    // every known name
    add_text("&amp;&lt;&gt;&quot;&apos;&nbsp;", 0);
    flush_doc();
    // one byte document
    add_text("Z", 0);
    flush_doc();

    base = feed_q.size();
    while (feed_q.size() - base < 226) make_doc();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (feed_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d documents, %0d bytes, %0d text beats", ends_seen, bytes_sent,
             chars_seen);
    $display("widest space run %0d, %0d mismatches", widest_gap, fails);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout, %0d beats still expected", expected_text.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
hdl/htts_pkg.sv
hdl/htts_front.sv
hdl/htts_back.sv
hdl/html_to_text_stripper_top.sv
test/tb_top.sv
